// ----- src/alu_with_prime_search_defines.svh -----
// ----------------------------------------------------------------------------
// ALU with prime search - assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ALU_WITH_PRIME_SEARCH_DEFINES_SVH
`define ALU_WITH_PRIME_SEARCH_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define ALUPS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("port check failed");

// Check the consequent in the cycle after the antecedent.
`define ALUPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("port check failed");

`endif

// ----- src/alups_pkg.sv -----
// ----------------------------------------------------------------------------
// ALU with prime search - package
// Opcodes, status codes and field widths shared by the block and its checker.
// ----------------------------------------------------------------------------
package alups_pkg;

    localparam int FUNC_W   = 3;
    localparam int OPA_W    = 32;
    localparam int OPB_W    = 16;
    localparam int RESULT_W = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SUB   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MUL   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_DIV   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_PRIME = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DIVZERO  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NEGCOUNT = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd3;

endpackage

// ----- src/alu_with_prime_search.sv -----
// ----------------------------------------------------------------------------
// ALU with prime search: add/sub/mul inline, divide and prime search on one divider.
// Add/sub/mul/unknown/error results are registered; divides run a 32-step divider.
// Prime search steps candidates in ST_PNEXT, with an ST_PCHK compare and a divider run
// per odd trial divisor, and a last ST_PCHK per prime. One transaction at a time.
// Reset: sync active-low aresetn returns to idle; datapath registers keep values.
// ----------------------------------------------------------------------------
module alu_with_prime_search (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // input transaction
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [alups_pkg::FUNC_W-1:0]           s_func,
    input  logic signed [alups_pkg::OPA_W-1:0]     s_operand_a,
    input  logic signed [alups_pkg::OPB_W-1:0]     s_operand_b,
    // result transaction
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [alups_pkg::RESULT_W-1:0]  m_result,
    output logic [alups_pkg::STATUS_W-1:0]         m_status
);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,  // wait for an input transaction
        ST_DIV   = 5'b00010,  // run the shared divider, one quotient bit a cycle
        ST_PNEXT = 5'b00100,  // step to the next candidate and classify it
        ST_PCHK  = 5'b01000,  // compare trial divisor squared against candidate
        ST_DONE  = 5'b10000   // hold the result until it is taken
    } state_t;

    state_t        state_reg, state_next;

    // Result registers.
    logic [31:0]   result_reg, result_next;
    logic [1:0]    status_reg, status_next;

    // Prime search: candidate (33-bit signed to catch the step past 2^31-1),
    // primes found so far, primes asked for, trial divisor and its square.
    logic [32:0]   num_reg, num_next;
    logic [14:0]   found_reg, found_next;
    logic [14:0]   count_reg, count_next;
    logic [15:0]   trial_reg, trial_next;
    logic [33:0]   square_reg, square_next;

    // Shared restoring divider: partial remainder, dividend/quotient shifter,
    // divisor, step counter, and what the finished quotient is used for.
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   quo_reg, quo_next;
    logic [31:0]   dvs_reg, dvs_next;
    logic [4:0]    bit_cnt_reg, bit_cnt_next;
    logic          prime_mode_reg, prime_mode_next;
    logic          neg_reg, neg_next;

    // Divider step.
    logic [32:0]   rem_shift;
    logic [32:0]   rem_diff;
    logic          step_fits;
    logic [31:0]   step_rem;
    logic [31:0]   step_quo;

    // Operand helpers.
    logic [31:0]        opb_ext;
    logic [31:0]        opa_mag;
    logic [15:0]        opb_mag;
    logic [31:0]        mul_low;
    logic [32:0]        num_inc;

    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign step_fits = ~rem_diff[32];
    assign step_rem  = step_fits ? rem_diff[31:0] : rem_shift[31:0];
    assign step_quo  = {quo_reg[30:0], step_fits};

    assign opb_ext  = {{16{s_operand_b[15]}}, s_operand_b};
    assign opa_mag  = s_operand_a[31] ? 32'(-s_operand_a) : 32'(s_operand_a);
    assign opb_mag  = s_operand_b[15] ? 16'(-s_operand_b) : 16'(s_operand_b);
    // Low half of the product is the same for signed and unsigned operands.
    assign mul_low  = $unsigned(s_operand_a) * opb_ext;
    assign num_inc  = num_reg + 33'd1;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_DONE);
    assign m_result = result_reg;
    assign m_status = status_reg;

    always_comb begin
        state_next      = state_reg;
        result_next     = result_reg;
        status_next     = status_reg;
        num_next        = num_reg;
        found_next      = found_reg;
        count_next      = count_reg;
        trial_next      = trial_reg;
        square_next     = square_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        dvs_next        = dvs_reg;
        bit_cnt_next    = bit_cnt_reg;
        prime_mode_next = prime_mode_reg;
        neg_next        = neg_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    status_next = alups_pkg::STAT_OK;
                    result_next = '0;
                    state_next  = ST_DONE;
                    case (s_func)
                        alups_pkg::FUNC_ADD: begin
                            result_next = s_operand_a + opb_ext;
                        end
                        alups_pkg::FUNC_SUB: begin
                            result_next = s_operand_a - opb_ext;
                        end
                        alups_pkg::FUNC_MUL: begin
                            result_next = mul_low;
                        end
                        alups_pkg::FUNC_DIV: begin
                            if (s_operand_b == 16'sd0) begin
                                status_next = alups_pkg::STAT_DIVZERO;
                            end else if (s_operand_a == 32'sh8000_0000 &&
                                         s_operand_b == -16'sd1) begin
                                status_next = alups_pkg::STAT_OVERFLOW;
                            end else begin
                                // Divide magnitudes, fix the sign at the end.
                                rem_next        = '0;
                                quo_next        = opa_mag;
                                dvs_next        = {16'd0, opb_mag};
                                bit_cnt_next    = '0;
                                prime_mode_next = 1'b0;
                                neg_next        = s_operand_a[31] ^ s_operand_b[15];
                                state_next      = ST_DIV;
                            end
                        end
                        alups_pkg::FUNC_PRIME: begin
                            if (s_operand_b[15]) begin
                                status_next = alups_pkg::STAT_NEGCOUNT;
                            end else begin
                                num_next   = {s_operand_a[31], s_operand_a};
                                found_next = '0;
                                count_next = s_operand_b[14:0];
                                state_next = ST_PNEXT;
                            end
                        end
                        default: begin
                            result_next = '0;
                        end
                    endcase
                end
            end

            ST_PNEXT: begin
                if (found_reg == count_reg) begin
                    result_next = num_reg[31:0];
                    state_next  = ST_DONE;
                end else if (num_inc[32:31] == 2'b01) begin
                    // Stepped past the largest signed 32-bit value.
                    result_next = '0;
                    status_next = alups_pkg::STAT_OVERFLOW;
                    state_next  = ST_DONE;
                end else begin
                    num_next = num_inc;
                    if (num_inc[32] || num_inc[31:2] == 30'd0) begin
                        // Anything below four counts as prime.
                        found_next = found_reg + 15'd1;
                    end else if (num_inc[0]) begin
                        // Odd: trial-divide by 3, 5, 7, ... up to the root.
                        trial_next  = 16'd3;
                        square_next = 34'd9;
                        state_next  = ST_PCHK;
                    end
                    // Even and four or more: composite, try the next one.
                end
            end

            ST_PCHK: begin
                if (square_reg > {1'b0, num_reg}) begin
                    found_next = found_reg + 15'd1;
                    state_next = ST_PNEXT;
                end else begin
                    rem_next        = '0;
                    quo_next        = num_reg[31:0];
                    dvs_next        = {16'd0, trial_reg};
                    bit_cnt_next    = '0;
                    prime_mode_next = 1'b1;
                    state_next      = ST_DIV;
                end
            end

            ST_DIV: begin
                rem_next     = step_rem;
                quo_next     = step_quo;
                bit_cnt_next = bit_cnt_reg + 5'd1;
                if (bit_cnt_reg == 5'd31) begin
                    if (prime_mode_reg) begin
                        if (step_rem == 32'd0) begin
                            state_next = ST_PNEXT;
                        end else begin
                            // Advance the trial divisor by two; (d+2)^2 = d^2 + 4d + 4.
                            trial_next  = trial_reg + 16'd2;
                            square_next = square_reg + {16'd0, trial_reg, 2'b00} + 34'd4;
                            state_next  = ST_PCHK;
                        end
                    end else begin
                        result_next = neg_reg ? 32'(-step_quo) : step_quo;
                        state_next  = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers; the sequencer loads them before use.
    always_ff @(posedge aclk) begin
        result_reg     <= result_next;
        status_reg     <= status_next;
        num_reg        <= num_next;
        found_reg      <= found_next;
        count_reg      <= count_next;
        trial_reg      <= trial_next;
        square_reg     <= square_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        dvs_reg        <= dvs_next;
        bit_cnt_reg    <= bit_cnt_next;
        prime_mode_reg <= prime_mode_next;
        neg_reg        <= neg_next;
    end

endmodule

// ----- src/alups_checker.sv -----
// ----------------------------------------------------------------------------
// ALU with prime search - port checker
// Watches the top-level ports for sequencing and result rules.
// ----------------------------------------------------------------------------
`include "alu_with_prime_search_defines.svh"

module alups_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [alups_pkg::RESULT_W-1:0]  m_result,
    input logic [alups_pkg::STATUS_W-1:0]         m_status
);

    // Block goes busy right after taking a transaction.
    `ALUPS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    // A stalled result holds.
    `ALUPS_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_result) && $stable(m_status))

    // Never offer a result while taking new work.
    `ALUPS_ASSERT_NOW(a_one_side, m_valid, !s_ready)

    // Every error status carries a zero result.
    `ALUPS_ASSERT_NOW(a_error_zero, m_valid && m_status != alups_pkg::STAT_OK, m_result == 32'sd0)

endmodule

bind alu_with_prime_search alups_checker u_alups_checker (.*);

// ----- test/tb_alu_with_prime_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for alu_with_prime_search
// Drives opcode/operand transactions through the valid/ready input channel,
// predicts each result in an in-bench ALU and prime-search model, and checks
// every result transaction, field by field, against the oldest prediction.
// Both channels idle at random; one phase streams with no idling, and one
// pauses until every predicted result has been drained.
// ----------------------------------------------------------------------------
module tb_alu_with_prime_search;

    // Extremes of the operand fields.
    localparam logic signed [alups_pkg::OPA_W-1:0] OPA_MIN =
        {1'b1, {(alups_pkg::OPA_W-1){1'b0}}};
    localparam logic signed [alups_pkg::OPA_W-1:0] OPA_MAX =
        {1'b0, {(alups_pkg::OPA_W-1){1'b1}}};
    localparam logic signed [alups_pkg::OPB_W-1:0] OPB_MIN =
        {1'b1, {(alups_pkg::OPB_W-1){1'b0}}};
    localparam logic signed [alups_pkg::OPB_W-1:0] OPB_MAX =
        {1'b0, {(alups_pkg::OPB_W-1){1'b1}}};

    // Opcodes above the last defined one do nothing and return zero.
    localparam logic [alups_pkg::FUNC_W-1:0] FUNC_LAST = alups_pkg::FUNC_PRIME;

    // Longest stretch with no accepted transaction on either channel. The
    // slowest item is a search over 32767 candidates below 4, each stepped in
    // ST_PNEXT; divides and small prime searches are far shorter.
    localparam int WATCHDOG_LIMIT = 500000;
    // Cycles to wait after the last result; covers a full divide.
    localparam int TAIL_CYCLES    = 80;

    typedef struct packed {
        logic signed [alups_pkg::RESULT_W-1:0] result;
        logic [alups_pkg::STATUS_W-1:0]        status;
    } alu_result_t;

    logic                                  aclk        = 1'b0;
    logic                                  aresetn     = 1'b0;
    logic                                  s_valid     = 1'b0;
    logic                                  s_ready;
    logic [alups_pkg::FUNC_W-1:0]          s_func      = '0;
    logic signed [alups_pkg::OPA_W-1:0]    s_operand_a = '0;
    logic signed [alups_pkg::OPB_W-1:0]    s_operand_b = '0;
    logic                                  m_valid;
    logic                                  m_ready     = 1'b0;
    logic signed [alups_pkg::RESULT_W-1:0] m_result;
    logic [alups_pkg::STATUS_W-1:0]        m_status;

    alu_result_t pending_results[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;
    bit          streaming      = 1'b0;   // no gaps on either side while set

    always #1 aclk = ~aclk;

    alu_with_prime_search i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_operand_a (s_operand_a),
        .s_operand_b (s_operand_b),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_result    (m_result),
        .m_status    (m_status)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Anything below 4 counts as prime, negatives included. Above that,
    // trial division up to the square root gives the same answer as the
    // block's search over odd trial divisors up to the root.
    function automatic bit counts_as_prime(input longint num);
        longint d;
        if (num < 4) return 1'b1;
        for (d = 2; d * d <= num; d++) begin
            if (num % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic alu_result_t alu_model(
        input logic [alups_pkg::FUNC_W-1:0]       func,
        input logic signed [alups_pkg::OPA_W-1:0] a,
        input logic signed [alups_pkg::OPB_W-1:0] b
    );
        alu_result_t                        r;
        logic signed [alups_pkg::OPA_W-1:0] bx;
        longint                             num;
        longint                             found;
        r.result = '0;
        r.status = alups_pkg::STAT_OK;
        bx = b;   // sign-extend to the ALU width
        case (func)
            alups_pkg::FUNC_ADD: r.result = a + bx;
            alups_pkg::FUNC_SUB: r.result = a - bx;
            alups_pkg::FUNC_MUL: r.result = a * bx;
            alups_pkg::FUNC_DIV: begin
                if (b == 0) begin
                    r.status = alups_pkg::STAT_DIVZERO;
                end else if (a == OPA_MIN && b == -1) begin
                    r.status = alups_pkg::STAT_OVERFLOW;
                end else begin
                    r.result = a / bx;   // signed, truncates toward zero
                end
            end
            alups_pkg::FUNC_PRIME: begin
                if (b < 0) begin
                    r.status = alups_pkg::STAT_NEGCOUNT;
                end else begin
                    // Step first, then test; stop on leaving the 32-bit range.
                    num   = a;
                    found = 0;
                    while (found < b) begin
                        num++;
                        if (num > longint'(OPA_MAX)) begin
                            r.status = alups_pkg::STAT_OVERFLOW;
                            break;
                        end
                        if (counts_as_prime(num)) found++;
                    end
                    if (r.status == alups_pkg::STAT_OK) begin
                        r.result = num[alups_pkg::RESULT_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        if (streaming) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: hold m_ready low for a random number of cycles, then
    // raise it for at least one cycle.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no prediction: result %0d status %0d",
                       m_result, m_status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result !== want.result) begin
                    $error("result: expected %0d, got %0d", want.result, m_result);
                    mismatch_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one transaction. Called and returns at a rising edge; s_valid is
    // left high after acceptance so back-to-back items never drop it.
    task automatic issue_op(input logic [alups_pkg::FUNC_W-1:0]       func,
                            input logic signed [alups_pkg::OPA_W-1:0] a,
                            input logic signed [alups_pkg::OPB_W-1:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= func;
        s_operand_a <= a;
        s_operand_b <= b;
        // Hold the payload until the block takes it.
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(alu_model(func, a, b));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Operands biased toward the extremes and the values around zero.
    function automatic logic signed [alups_pkg::OPA_W-1:0] pick_opa();
        case ($urandom_range(0, 9))
            0: return OPA_MIN;
            1: return OPA_MAX;
            2: return '0;
            3: return -1;
            4: return $signed(32'($urandom_range(0, 40))) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [alups_pkg::OPB_W-1:0] pick_opb();
        case ($urandom_range(0, 9))
            0: return OPB_MIN;
            1: return OPB_MAX;
            2: return '0;
            3: return -16'sd1;
            4: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
            default: return 16'($urandom);
        endcase
    endfunction

    // Prime search arguments kept cheap: small starts with few primes, deep
    // negative starts that stay below 4, negative counts, and zero counts.
    task automatic pick_prime_args(output logic signed [alups_pkg::OPA_W-1:0] a,
                                   output logic signed [alups_pkg::OPB_W-1:0] b);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            a = $signed(32'($urandom_range(0, 110))) - 50;
            b = 16'($urandom_range(0, 4));
        end else if (r < 75) begin
            a = $signed({1'b1, 31'($urandom)});
            if (a > -100) a = -100;
            b = 16'($urandom_range(0, 60));
        end else if (r < 88) begin
            a = $urandom;
            b = $signed({1'b1, 15'($urandom)});
        end else begin
            a = $urandom;
            b = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wrap-around at the extremes for add, subtract and multiply.
    task automatic test_arith_edges();
        issue_op(alups_pkg::FUNC_ADD, OPA_MAX, 16'sd1);
        issue_op(alups_pkg::FUNC_ADD, OPA_MIN, -16'sd1);
        issue_op(alups_pkg::FUNC_SUB, OPA_MIN, 16'sd1);
        issue_op(alups_pkg::FUNC_SUB, '0, OPB_MIN);
        issue_op(alups_pkg::FUNC_MUL, OPA_MAX, OPB_MAX);
        issue_op(alups_pkg::FUNC_MUL, OPA_MIN, -16'sd1);
    endtask

    // Divide by zero, the one overflowing quotient, and truncation.
    task automatic test_divide_cases();
        issue_op(alups_pkg::FUNC_DIV, 32'sd7, '0);
        issue_op(alups_pkg::FUNC_DIV, OPA_MIN, -16'sd1);
        issue_op(alups_pkg::FUNC_DIV, OPA_MIN, 16'sd1);
        issue_op(alups_pkg::FUNC_DIV, -32'sd7, 16'sd2);
        issue_op(alups_pkg::FUNC_DIV, OPA_MAX, OPB_MIN);
    endtask

    // Zero and negative counts, the below-4 region, running off the top of
    // the range, the largest count, and ordinary searches over composites.
    task automatic test_prime_cases();
        issue_op(alups_pkg::FUNC_PRIME, OPA_MAX, '0);
        issue_op(alups_pkg::FUNC_PRIME, 32'sd10, -16'sd1);
        issue_op(alups_pkg::FUNC_PRIME, 32'sd10, OPB_MIN);
        issue_op(alups_pkg::FUNC_PRIME, -32'sd3, 16'sd5);
        issue_op(alups_pkg::FUNC_PRIME, OPA_MAX, 16'sd1);
        issue_op(alups_pkg::FUNC_PRIME, OPA_MIN, OPB_MAX);
        issue_op(alups_pkg::FUNC_PRIME, 32'sd3, 16'sd2);
        issue_op(alups_pkg::FUNC_PRIME, 32'sd24, 16'sd1);
    endtask

    // Opcodes past the last defined one.
    task automatic test_unknown_ops();
        issue_op(FUNC_LAST + 3'd1, OPA_MAX, OPB_MAX);
        issue_op(FUNC_LAST + 3'd2, OPA_MIN, OPB_MIN);
        issue_op(FUNC_LAST + 3'd3, -1, -16'sd1);
    endtask

    // Weighted random mix over every opcode.
    task automatic test_random_traffic(input int count);
        int                                 k;
        int                                 pick;
        logic [alups_pkg::FUNC_W-1:0]       f;
        logic signed [alups_pkg::OPA_W-1:0] a;
        logic signed [alups_pkg::OPB_W-1:0] b;
        for (k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                f = alups_pkg::FUNC_ADD + 3'($urandom_range(0, 2));
                a = pick_opa();
                b = pick_opb();
            end else if (pick < 75) begin
                f = alups_pkg::FUNC_DIV;
                a = pick_opa();
                b = pick_opb();
                if ($urandom_range(0, 15) == 0) begin
                    a = OPA_MIN;
                    b = -16'sd1;
                end
            end else if (pick < 92) begin
                f = alups_pkg::FUNC_PRIME;
                pick_prime_args(a, b);
            end else begin
                f = FUNC_LAST + 3'($urandom_range(1, 3));
                a = $urandom;
                b = 16'($urandom);
            end
            issue_op(f, a, b);
        end
    endtask

    // Back-to-back transactions with no idling on either side.
    task automatic test_streaming(input int count);
        streaming = 1'b1;
        test_random_traffic(count);
        streaming = 1'b0;
    endtask

    // Hold the sender until the block has returned everything, then resume.
    task automatic test_pause_until_empty();
        issue_op(alups_pkg::FUNC_DIV, pick_opa(), 16'sd3);
        issue_op(alups_pkg::FUNC_PRIME, 32'sd40, 16'sd2);
        drain_results();
        issue_op(alups_pkg::FUNC_MUL, pick_opa(), pick_opb());
        test_random_traffic(30);
    endtask

    initial begin
        // Reset once, then release at an edge.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_arith_edges();
        test_divide_cases();
        test_prime_cases();
        test_unknown_ops();
        test_random_traffic(400);
        test_streaming(60);
        test_pause_until_empty();
        test_random_traffic(390);

        drain_results();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- alu_with_prime_search.f -----
+incdir+src
src/alups_pkg.sv
src/alu_with_prime_search.sv
src/alups_checker.sv
test/tb_alu_with_prime_search.sv
